@@ sv/cosw_pkg.sv @@
// cosw_pkg: shared constants, types and helpers for the Collatz odd-step sweep.
// No dependencies; imported by cosw_core and collatz_odd_step_sweep_top.
`default_nettype none
package cosw_pkg;

  localparam int VALUE_WORDS = 8;
  localparam int AW = $clog2(VALUE_WORDS);
  localparam int CW = $clog2(VALUE_WORDS + 1);
  localparam int KW = 10;

  localparam logic [18:0] STEP_LIMIT = 19'd500000;
  localparam int LARGE_EXP = 125;
  localparam logic [63:0] LARGE_HI = 64'd1 << (LARGE_EXP - 64);

  localparam logic [CW-1:0] WORDS_C = CW'(VALUE_WORDS);
  localparam logic [CW-1:0] LAST_C = CW'(VALUE_WORDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TRI,
    ST_STRIP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [18:0] step_count;
    logic        skipped;
    logic        went_large;
    logic [18:0] best_count;
    logic [63:0] best_multiplier;
    logic [63:0] large_total;
  } res_t;

  function automatic logic [5:0] trail_zeros(input logic [63:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int b = 63; b >= 0; b--) begin
      if (v[b]) n = 6'(b);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

@@ sv/cosw_in_if.sv @@
// cosw_in_if: input channel, valid/ready with multiplier and sweep flag.
// Depends on nothing.
`default_nettype none
interface cosw_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] multiplier;
  logic        new_sweep;
  modport source (output valid, output multiplier, output new_sweep, input ready);
  modport sink (input valid, input multiplier, input new_sweep, output ready);
endinterface
`default_nettype wire

@@ sv/cosw_out_if.sv @@
// cosw_out_if: result channel, valid/ready with the per-item result fields.
// Depends on nothing.
`default_nettype none
interface cosw_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] step_count;
  logic        skipped;
  logic        went_large;
  logic [18:0] best_count;
  logic [63:0] best_multiplier;
  logic [63:0] large_total;
  modport source (output valid, output step_count, output skipped, output went_large,
                  output best_count, output best_multiplier, output large_total,
                  input ready);
  modport sink (input valid, input step_count, input skipped, input went_large,
                input best_count, input best_multiplier, input large_total,
                output ready);
endinterface
`default_nettype wire

@@ sv/cosw_ram.sv @@
// cosw_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module cosw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/cosw_core.sv @@
// cosw_core: sequencer for load, 3n+1 and zero-strip passes over the value RAM,
// plus the running best and large counter. Depends on cosw_pkg, cosw_ram.
`default_nettype none
module cosw_core import cosw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [8:0]  shift_amount,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_multiplier,
  input  wire logic        in_new_sweep,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_t             res
);
  state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r;
  logic          rv_r, rz_r;
  logic [CW-1:0] ri_r;
  logic [63:0]   m_r;
  logic [KW-1:0] k_r;
  logic          borrow_r;
  logic [1:0]    carry_r;
  logic          one_r, large_r, w0nz_r, found_r;
  logic          item_large_r, skip_r;
  logic [AW-1:0] fz_r;
  logic [5:0]    bs_r;
  logic [63:0]   prev_r;
  logic [18:0]   steps_r, best_r;
  logic [63:0]   best_m_r, ltot_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  cosw_ram #(.WIDTH(64), .DEPTH(VALUE_WORDS)) u_val (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // load word
  logic [3:0]   ws;
  logic [5:0]   bs;
  logic [127:0] mshift;
  logic [63:0]  base;
  logic         fit_over, borrow_out;
  assign ws = k_r[9:6];
  assign bs = k_r[5:0];
  assign mshift = {64'd0, m_r} << bs;
  always_comb begin
    base = 64'd0;
    if ({1'b0, ws} == 5'(cnt_r)) base = mshift[63:0];
    else if ({1'b0, ws} + 5'd1 == 5'(cnt_r)) base = mshift[127:64];
  end
  assign fit_over = (({1'b0, ws} >= 5'(VALUE_WORDS)) && (m_r != 64'd0)) ||
                    (({1'b0, ws} == 5'(VALUE_WORDS - 1)) && (mshift[127:64] != 64'd0));
  assign borrow_out = borrow_r && (base == 64'd0);

  // triple pass
  logic [65:0] tri_sum;
  logic        w_one, w_large, fin_one, fin_large;
  assign tri_sum = {2'b00, rdata} + {1'b0, rdata, 1'b0} + {64'd0, carry_r};
  always_comb begin
    w_one = (ri_r == '0) ? (rdata == 64'd1) : (rdata == 64'd0);
    w_large = 1'b0;
    if (ri_r >= CW'(2)) w_large = rdata != 64'd0;
    else if (ri_r == CW'(1)) w_large = (rdata > LARGE_HI) || ((rdata == LARGE_HI) && w0nz_r);
  end
  assign fin_one = one_r && w_one;
  assign fin_large = large_r || w_large;

  // strip pass
  logic [CW-1:0]  saddr;
  logic [63:0]    sdata;
  logic [127:0]   sjoin;
  logic [18:0]    steps_inc;
  assign saddr = CW'(fz_r) + cnt_r;
  assign sdata = rz_r ? 64'd0 : rdata;
  assign sjoin = {sdata, prev_r} >> bs_r;
  assign steps_inc = steps_r + 19'd1;

  logic tri_last, strip_last;
  assign tri_last = rv_r && (ri_r == LAST_C);
  assign strip_last = rv_r && (ri_r == WORDS_C);

  // result
  logic        better;
  logic [63:0] ltot_new;
  assign better = !skip_r && (steps_r > best_r);
  assign ltot_new = (item_large_r && (ltot_r != '1)) ? ltot_r + 64'd1 : ltot_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD:  if (cnt_r == LAST_C) state_nxt = (fit_over || borrow_out) ? ST_DONE : ST_TRI;
      ST_TRI:   if (tri_last) state_nxt = (fin_one || tri_sum[65:64] != 2'b00) ? ST_DONE
                                                                                : ST_STRIP;
      ST_STRIP: if (strip_last) state_nxt = (steps_inc > STEP_LIMIT) ? ST_DONE : ST_TRI;
      ST_DONE:  if (res_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state_r == ST_IDLE;
    res_valid = state_r == ST_DONE;
    res.step_count = steps_r;
    res.skipped = skip_r;
    res.went_large = item_large_r;
    res.best_count = better ? steps_r : best_r;
    res.best_multiplier = better ? m_r : best_m_r;
    res.large_total = ltot_new;
    we = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = base - {63'd0, borrow_r};
    raddr = cnt_r[AW-1:0];
    unique case (state_r)
      ST_LOAD: we = 1'b1;
      ST_TRI: begin
        we = rv_r;
        waddr = ri_r[AW-1:0];
        wdata = tri_sum[63:0];
      end
      ST_STRIP: begin
        we = rv_r && (ri_r != '0);
        waddr = AW'(ri_r - CW'(1));
        wdata = sjoin[63:0];
        raddr = saddr[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rv_r <= 1'b0;
      steps_r <= '0;
      best_r <= '0;
      best_m_r <= '0;
      ltot_r <= '0;
    end else begin
      state_r <= state_nxt;
      rv_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          m_r <= in_multiplier;
          k_r <= KW'(shift_amount) + KW'(1);
          cnt_r <= '0;
          borrow_r <= 1'b1;
          steps_r <= '0;
          skip_r <= 1'b0;
          item_large_r <= 1'b0;
          if (in_new_sweep) begin
            best_r <= '0;
            best_m_r <= '0;
            ltot_r <= '0;
          end
        end
        ST_LOAD: begin
          borrow_r <= borrow_out;
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == LAST_C) begin
            cnt_r <= '0;
            carry_r <= 2'd1;
            one_r <= 1'b1;
            large_r <= 1'b0;
            found_r <= 1'b0;
            if (fit_over || borrow_out) begin
              skip_r <= 1'b1;
              item_large_r <= 1'b1;
            end
          end
        end
        ST_TRI: begin
          if (cnt_r != WORDS_C) begin
            cnt_r <= cnt_r + CW'(1);
            rv_r <= 1'b1;
            ri_r <= cnt_r;
          end
          if (rv_r) begin
            carry_r <= tri_sum[65:64];
            one_r <= fin_one;
            large_r <= fin_large;
            if (ri_r == '0) w0nz_r <= rdata != 64'd0;
            if (!found_r && tri_sum[63:0] != 64'd0) begin
              found_r <= 1'b1;
              fz_r <= ri_r[AW-1:0];
              bs_r <= trail_zeros(tri_sum[63:0]);
            end
          end
          if (tri_last) begin
            cnt_r <= '0;
            if (!fin_one) begin
              item_large_r <= item_large_r || fin_large;
              if (tri_sum[65:64] != 2'b00) skip_r <= 1'b1;
            end
          end
        end
        ST_STRIP: begin
          if (cnt_r <= WORDS_C) begin
            cnt_r <= cnt_r + CW'(1);
            rv_r <= 1'b1;
            ri_r <= cnt_r;
            rz_r <= saddr >= WORDS_C;
          end
          if (rv_r) prev_r <= sdata;
          if (strip_last) begin
            rv_r <= 1'b0;
            cnt_r <= '0;
            steps_r <= steps_inc;
            carry_r <= 2'd1;
            one_r <= 1'b1;
            large_r <= 1'b0;
            found_r <= 1'b0;
            if (steps_inc > STEP_LIMIT) skip_r <= 1'b1;
          end
        end
        ST_DONE: if (res_ready) begin
          ltot_r <= ltot_new;
          if (better) begin
            best_r <= steps_r;
            best_m_r <= m_r;
          end
        end
        default: ;
      endcase
    end
  end

  a_steps_cap: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= STEP_LIMIT + 19'd1) else $error("step count beyond limit");
  a_idle_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !we) else $error("value RAM written while idle");
  a_best_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.skipped) |-> (res.best_count >= res.step_count))
    else $error("running best below a counted item");
  a_strip_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STRIP) |-> found_r) else $error("strip without a nonzero word");
endmodule
`default_nettype wire

@@ sv/collatz_odd_step_sweep_top.sv @@
// Collatz odd-step sweep: for each multiplier m, n = (m << (j+1)) - 1 is iterated
// with the odd step n = (3n+1) stripped of trailing zeros until n is 1 or the item is skipped.
//
// Channels: in_ch (multiplier, new_sweep) and out_ch (one result per item), both
// valid/ready; a transfer happens on a rising edge with valid and ready high.
// cfg_we/cfg_wdata write shift_amount (j); write only while the block is idle.
//
// The working value sits in a VALUE_WORDS x 64-bit RAM, processed one word a cycle.
// Each item is loaded, then each odd step runs a 3n+1 pass and a strip pass, and a
// closing 3n+1 pass finds n = 1 before the result enters the output register; a
// start value that does not fit ends the item after the load. One item is in
// flight: a new one is taken only once the previous result has left the sequencer.
// The result goes to an output register, so the next item can start while the
// previous result waits; a stalled out_ch holds the result and the sequencer
// waits in its final state once both are full.
// Reset (synchronous, rst_n low) clears j, the running best and the large count;
// no clearing pass is needed, the value RAM is loaded in full for each item.
// new_sweep on an item clears the running best and large count before it.
`default_nettype none
module collatz_odd_step_sweep_top import cosw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  cosw_in_if.sink         in_ch,
  cosw_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata
);
  logic [8:0] shift_r;
  logic       res_valid, res_ready, ovalid_r;
  res_t       res, ores_r;

  always_ff @(posedge clk) begin
    if (!rst_n) shift_r <= '0;
    else if (cfg_we) shift_r <= cfg_wdata;
  end

  cosw_core u_core (
    .clk(clk), .rst_n(rst_n), .shift_amount(shift_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_multiplier(in_ch.multiplier), .in_new_sweep(in_ch.new_sweep),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  assign res_ready = !ovalid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (res_ready) ovalid_r <= res_valid;
    if (res_ready && res_valid) ores_r <= res;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.step_count = ores_r.step_count;
  assign out_ch.skipped = ores_r.skipped;
  assign out_ch.went_large = ores_r.went_large;
  assign out_ch.best_count = ores_r.best_count;
  assign out_ch.best_multiplier = ores_r.best_multiplier;
  assign out_ch.large_total = ores_r.large_total;
endmodule
`default_nettype wire
